// ===== sv/chunked_transfer_decoder_top_defines.svh =====
// Assertion macros shared by the chunked transfer decoder RTL.
`ifndef CHUNKED_TRANSFER_DECODER_TOP_DEFINES_SVH
`define CHUNKED_TRANSFER_DECODER_TOP_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define CTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication whose consequent must hold in the cycle after its antecedent.
`define CTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ctd_pkg.sv =====
// Shared phase codes, result type and hex digit decode for the chunked decoder.
`default_nettype none
package ctd_pkg;

  localparam logic [1:0] PH_SIZE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_LINE = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [7:0] CHAR_LF = 8'h0a;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [1:0] state_code;
  } ctd_res_t;

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ctd_step.sv =====
// Next-state and result logic for one byte of the chunked decoder.
`default_nettype none
module ctd_step
  import ctd_pkg::*;
#(
  parameter int SIZE_WIDTH = 32
) (
  input  wire logic [1:0]            phase_i,
  input  wire logic [SIZE_WIDTH-1:0] size_i,
  input  wire logic [SIZE_WIDTH-1:0] remaining_i,
  input  wire logic [7:0]            in_byte_i,
  input  wire logic                  restart_i,
  output logic      [1:0]            phase_o,
  output logic      [SIZE_WIDTH-1:0] size_o,
  output logic      [SIZE_WIDTH-1:0] remaining_o,
  output ctd_res_t                   res_o
);

  logic [1:0]            ph;
  logic [SIZE_WIDTH-1:0] sz;
  logic [SIZE_WIDTH-1:0] rem;
  logic [SIZE_WIDTH-1:0] rem_dec;
  logic [4:0]            hex;

  assign hex = hex_decode(in_byte_i);

  always_comb begin
    // Restart takes effect before the byte.
    ph  = restart_i ? PH_SIZE : phase_i;
    sz  = restart_i ? '0 : size_i;
    rem = restart_i ? '0 : remaining_i;
    rem_dec = rem - SIZE_WIDTH'(1);

    phase_o          = ph;
    size_o           = sz;
    remaining_o      = rem;
    res_o.data_valid = 1'b0;
    res_o.data_byte  = 8'd0;

    unique case (ph)
      PH_SIZE: begin
        if (hex[4]) begin
          size_o = {sz[SIZE_WIDTH-5:0], hex[3:0]};
        end else if (in_byte_i == CHAR_LF) begin
          if (sz == '0) begin
            phase_o = PH_DONE;
          end else begin
            remaining_o = sz;
            phase_o     = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (rem != '0) begin
          res_o.data_valid = 1'b1;
          res_o.data_byte  = in_byte_i;
          remaining_o      = rem_dec;
          if (rem_dec == '0) begin
            phase_o = PH_LINE;
          end
        end else begin
          phase_o = PH_LINE;
        end
      end
      PH_LINE: begin
        if (in_byte_i == CHAR_LF) begin
          size_o  = '0;
          phase_o = PH_SIZE;
        end
      end
      default: begin
        // Done: swallow the byte.
      end
    endcase

    res_o.state_code = phase_o;
  end

endmodule
`default_nettype wire

// ===== sv/chunked_transfer_decoder_top.sv =====
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while out_ready_i is high; the single output register frees as it is taken.
// The per-byte update is one hex shift or one count decrement with a zero compare.
// Reset: asynchronous, active low; phase returns to size, size and count clear,
// and the output register empties.
`default_nettype none
`include "chunked_transfer_decoder_top_defines.svh"
module chunked_transfer_decoder_top
  import ctd_pkg::*;
#(
  parameter int SIZE_WIDTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       restart_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            data_valid_o,
  output logic      [7:0] data_byte_o,
  output logic      [1:0] state_code_o
);

  logic [1:0]            phase_q, phase_d;
  logic [SIZE_WIDTH-1:0] size_q, size_d;
  logic [SIZE_WIDTH-1:0] remaining_q, remaining_d;
  ctd_res_t              res_q, res_d;
  logic                  out_valid_q;
  logic                  in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  ctd_step #(
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_step (
    .phase_i    (phase_q),
    .size_i     (size_q),
    .remaining_i(remaining_q),
    .in_byte_i  (in_byte_i),
    .restart_i  (restart_i),
    .phase_o    (phase_d),
    .size_o     (size_d),
    .remaining_o(remaining_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIZE;
      size_q      <= '0;
      remaining_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q     <= phase_d;
        size_q      <= size_d;
        remaining_q <= remaining_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result word until it is taken.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_valid_o = res_q.data_valid;
  assign data_byte_o  = res_q.data_byte;
  assign state_code_o = res_q.state_code;

  `CTD_ASSERT(a_data_phase_count, (phase_q != PH_DATA) || (remaining_q != '0), "data phase with zero count")
  `CTD_ASSERT(a_out_tracks_phase, !out_valid_q || (res_q.state_code == phase_q), "result phase differs from state")
  `CTD_ASSERT(a_payload_phase, !(out_valid_q && res_q.data_valid) || (res_q.state_code == PH_DATA) || (res_q.state_code == PH_LINE), "payload outside data phase")
  `CTD_ASSERT_NEXT(a_done_swallows, in_fire && !restart_i && (phase_q == PH_DONE), !res_q.data_valid && (res_q.state_code == PH_DONE), "done phase left or emitted")

endmodule
`default_nettype wire
